@@ hw/rtl/positional_sequence_store_assert.svh @@
// ----------------------------------------------------------------------------
// positional_sequence_store_assert.svh
// Assertion macros used by the checker of the positional sequence store.
// ----------------------------------------------------------------------------
`ifndef POSITIONAL_SEQUENCE_STORE_ASSERT_SVH
`define POSITIONAL_SEQUENCE_STORE_ASSERT_SVH

// Same-cycle implication, sampled on i_clk, off during reset.
`define PSQ_ASSERT_SAME(label, ante, cons) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |-> (cons)) \
        else $error("positional_sequence_store: assertion failed");

// Next-cycle implication, sampled on i_clk, off during reset.
`define PSQ_ASSERT_NEXT(label, ante, cons) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |=> (cons)) \
        else $error("positional_sequence_store: assertion failed");

`endif

@@ hw/rtl/psq_pkg.sv @@
// ----------------------------------------------------------------------------
// psq_pkg
// Types, codes and default sizes of the positional sequence store.
// ----------------------------------------------------------------------------
package psq_pkg;

    // Default storage sizes
    localparam int PSQ_DEPTH      = 16;
    localparam int PSQ_DATA_WIDTH = 32;

    // Request modes
    localparam logic [2:0] MODE_READ   = 3'd0;
    localparam logic [2:0] MODE_APPEND = 3'd1;
    localparam logic [2:0] MODE_INSERT = 3'd2;
    localparam logic [2:0] MODE_DELETE = 3'd3;
    localparam logic [2:0] MODE_CLEAR  = 3'd4;

    // Response status codes
    localparam logic [1:0] ST_OK      = 2'd0;
    localparam logic [1:0] ST_BAD_POS = 2'd1;
    localparam logic [1:0] ST_FULL    = 2'd2;

    typedef struct packed {
        logic [2:0]  mode;
        logic [4:0]  position;
        logic [31:0] value;
    } t_req;

    typedef struct packed {
        logic [31:0] read_value;
        logic [4:0]  count;
        logic [1:0]  status;
    } t_resp;

endpackage

@@ hw/rtl/psq_ram.sv @@
// ----------------------------------------------------------------------------
// psq_ram
// Generic simple dual-port RAM: one write port, one read port, registered read.
// ----------------------------------------------------------------------------
module psq_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 16,
    localparam int AW   = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
    input  logic             i_clk,
    input  logic             i_wr_en,
    input  logic [AW-1:0]    i_wr_addr,
    input  logic [WIDTH-1:0] i_wr_data,
    input  logic             i_rd_en,
    input  logic [AW-1:0]    i_rd_addr,
    output logic [WIDTH-1:0] o_rd_data
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rd_data;

    // Write and registered read
    always_ff @(posedge i_clk) begin
        if (i_wr_en) begin
            r_mem[i_wr_addr] <= i_wr_data;
        end
        if (i_rd_en) begin
            r_rd_data <= r_mem[i_rd_addr];
        end
    end

    assign o_rd_data = r_rd_data;

endmodule

@@ hw/rtl/psq_ctrl.sv @@
// ----------------------------------------------------------------------------
// psq_ctrl
// Request sequencer: checks each request, walks the entry memory to shift
// entries on insert and delete, and holds the response register.
// ----------------------------------------------------------------------------
module psq_ctrl
    import psq_pkg::*;
#(
    parameter int DEPTH      = PSQ_DEPTH,
    parameter int DATA_WIDTH = PSQ_DATA_WIDTH,
    localparam int AW        = (DEPTH > 1) ? $clog2(DEPTH) : 1,
    localparam int CW        = $clog2(DEPTH + 1)
) (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  logic                  i_req_valid,
    output logic                  o_req_stall,
    input  t_req                  i_req,
    output logic                  o_resp_valid,
    input  logic                  i_resp_stall,
    output t_resp                 o_resp,
    output logic                  o_mem_wr_en,
    output logic [AW-1:0]         o_mem_wr_addr,
    output logic [DATA_WIDTH-1:0] o_mem_wr_data,
    output logic                  o_mem_rd_en,
    output logic [AW-1:0]         o_mem_rd_addr,
    input  logic [DATA_WIDTH-1:0] i_mem_rd_data
);

    localparam int            CMPW  = (CW > 5) ? CW : 5;
    localparam logic [AW-1:0] ONE_A = AW'(1);
    localparam logic [CW-1:0] ONE_C = CW'(1);
    localparam logic [CW-1:0] FULL_C = CW'(DEPTH);

    typedef enum logic [2:0] {
        S_IDLE,
        S_READ,
        S_INS,
        S_INS_FIN,
        S_DEL,
        S_RESP
    } t_state;

    t_state                r_state, n_state;
    logic [CW-1:0]         r_count, n_count;
    logic [AW-1:0]         r_idx, n_idx;
    logic [AW-1:0]         r_pos, n_pos;
    logic [DATA_WIDTH-1:0] r_val, n_val;
    logic [31:0]           r_rd_value, n_rd_value;
    logic [1:0]            r_status, n_status;
    logic                  r_resp_valid, n_resp_valid;
    t_resp                 r_resp, n_resp;

    logic [CMPW-1:0]       pos_ext;
    logic [CMPW-1:0]       cnt_ext;
    logic [CW-1:0]         cnt_m1;
    logic [AW-1:0]         pos_a;
    logic [AW-1:0]         last_a;
    logic                  full;

    // Compare position and count at a common width
    assign pos_ext = CMPW'(i_req.position);
    assign cnt_ext = CMPW'(r_count);
    assign cnt_m1  = r_count - ONE_C;
    assign pos_a   = pos_ext[AW-1:0];
    assign last_a  = cnt_m1[AW-1:0];
    assign full    = (r_count == FULL_C);

    assign o_req_stall  = (r_state != S_IDLE);
    assign o_resp_valid = r_resp_valid;
    assign o_resp       = r_resp;

    // Next state, memory commands and response fields
    always_comb begin
        n_state       = r_state;
        n_count       = r_count;
        n_idx         = r_idx;
        n_pos         = r_pos;
        n_val         = r_val;
        n_rd_value    = r_rd_value;
        n_status      = r_status;
        n_resp_valid  = r_resp_valid & i_resp_stall;
        n_resp        = r_resp;
        o_mem_wr_en   = 1'b0;
        o_mem_wr_addr = r_idx;
        o_mem_wr_data = i_mem_rd_data;
        o_mem_rd_en   = 1'b0;
        o_mem_rd_addr = r_idx;

        case (r_state)
            S_IDLE: begin
                if (i_req_valid) begin
                    n_rd_value = '0;
                    n_status   = ST_OK;
                    n_state    = S_RESP;
                    n_pos      = pos_a;
                    n_val      = DATA_WIDTH'(i_req.value);
                    case (i_req.mode)
                        MODE_READ: begin
                            if (pos_ext < cnt_ext) begin
                                o_mem_rd_en   = 1'b1;
                                o_mem_rd_addr = pos_a;
                                n_state       = S_READ;
                            end else begin
                                n_status = ST_BAD_POS;
                            end
                        end
                        MODE_APPEND: begin
                            if (full) begin
                                n_status = ST_FULL;
                            end else begin
                                o_mem_wr_en   = 1'b1;
                                o_mem_wr_addr = r_count[AW-1:0];
                                o_mem_wr_data = DATA_WIDTH'(i_req.value);
                                n_count       = r_count + ONE_C;
                            end
                        end
                        MODE_INSERT: begin
                            if (pos_ext > cnt_ext) begin
                                n_status = ST_BAD_POS;
                            end else if (full) begin
                                n_status = ST_FULL;
                            end else if (pos_ext == cnt_ext) begin
                                // insert at the end: no shift
                                o_mem_wr_en   = 1'b1;
                                o_mem_wr_addr = pos_a;
                                o_mem_wr_data = DATA_WIDTH'(i_req.value);
                                n_count       = r_count + ONE_C;
                            end else begin
                                // start shifting up from the tail
                                o_mem_rd_en   = 1'b1;
                                o_mem_rd_addr = last_a;
                                n_idx         = last_a;
                                n_state       = S_INS;
                            end
                        end
                        MODE_DELETE: begin
                            if (pos_ext >= cnt_ext) begin
                                n_status = ST_BAD_POS;
                            end else if (pos_a == last_a) begin
                                // delete the tail: no shift
                                n_count = cnt_m1;
                            end else begin
                                // start shifting down behind the position
                                o_mem_rd_en   = 1'b1;
                                o_mem_rd_addr = pos_a + ONE_A;
                                n_idx         = pos_a + ONE_A;
                                n_state       = S_DEL;
                            end
                        end
                        MODE_CLEAR: begin
                            n_count = '0;
                        end
                        default: begin
                        end
                    endcase
                end
            end
            S_READ: begin
                n_rd_value = 32'(i_mem_rd_data);
                n_state    = S_RESP;
            end
            S_INS: begin
                // move the entry read last cycle one place up
                o_mem_wr_en   = 1'b1;
                o_mem_wr_addr = r_idx + ONE_A;
                if (r_idx == r_pos) begin
                    n_state = S_INS_FIN;
                end else begin
                    o_mem_rd_en   = 1'b1;
                    o_mem_rd_addr = r_idx - ONE_A;
                    n_idx         = r_idx - ONE_A;
                end
            end
            S_INS_FIN: begin
                o_mem_wr_en   = 1'b1;
                o_mem_wr_addr = r_pos;
                o_mem_wr_data = r_val;
                n_count       = r_count + ONE_C;
                n_state       = S_RESP;
            end
            S_DEL: begin
                // move the entry read last cycle one place down
                o_mem_wr_en   = 1'b1;
                o_mem_wr_addr = r_idx - ONE_A;
                if (r_idx == last_a) begin
                    n_count = cnt_m1;
                    n_state = S_RESP;
                end else begin
                    o_mem_rd_en   = 1'b1;
                    o_mem_rd_addr = r_idx + ONE_A;
                    n_idx         = r_idx + ONE_A;
                end
            end
            S_RESP: begin
                // load the response once the output register is free
                if (!r_resp_valid || !i_resp_stall) begin
                    n_resp_valid      = 1'b1;
                    n_resp.read_value = r_rd_value;
                    n_resp.count      = 5'(r_count);
                    n_resp.status     = r_status;
                    n_state           = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    // State and registered outputs
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state      <= S_IDLE;
            r_count      <= '0;
            r_resp_valid <= 1'b0;
        end else begin
            r_state      <= n_state;
            r_count      <= n_count;
            r_resp_valid <= n_resp_valid;
        end
        r_idx      <= n_idx;
        r_pos      <= n_pos;
        r_val      <= n_val;
        r_rd_value <= n_rd_value;
        r_status   <= n_status;
        r_resp     <= n_resp;
    end

endmodule

@@ hw/rtl/positional_sequence_store.sv @@
// ----------------------------------------------------------------------------
// positional_sequence_store
// Ordered sequence of up to DEPTH words, read, inserted and deleted by position.
// ----------------------------------------------------------------------------
// Usage:
//   Request channel: i_req_valid / o_req_stall carry t_req (mode, position,
//   value). Response channel: o_resp_valid / i_resp_stall carry t_resp
//   (read_value, count, status). Every request gives exactly one response.
//   One request is worked at a time; o_req_stall is high from the cycle after
//   acceptance until its response is loaded into the output register.
//   Insert and delete away from the tail run a shift loop that moves one
//   entry per cycle through the single write port of the entry memory;
//   the more entries a request shifts, the longer it takes.
//   The output register lets a new request be accepted while the previous
//   response waits; a stalled response holds, and the next result waits in
//   the sequencer until the register frees.
//   Reset empties the sequence (count 0) and drops any pending response.
//   Memory contents are not cleared; only written entries are ever read.
// ----------------------------------------------------------------------------
module positional_sequence_store
    import psq_pkg::*;
#(
    parameter int DEPTH      = PSQ_DEPTH,
    parameter int DATA_WIDTH = PSQ_DATA_WIDTH
) (
    input  logic  i_clk,
    input  logic  i_rst_n,
    input  logic  i_req_valid,
    output logic  o_req_stall,
    input  t_req  i_req,
    output logic  o_resp_valid,
    input  logic  i_resp_stall,
    output t_resp o_resp
);

    localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;

    logic                  mem_wr_en;
    logic [AW-1:0]         mem_wr_addr;
    logic [DATA_WIDTH-1:0] mem_wr_data;
    logic                  mem_rd_en;
    logic [AW-1:0]         mem_rd_addr;
    logic [DATA_WIDTH-1:0] mem_rd_data;

    // Sequencer
    psq_ctrl #(
        .DEPTH      (DEPTH),
        .DATA_WIDTH (DATA_WIDTH)
    ) u_ctrl (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_req_valid   (i_req_valid),
        .o_req_stall   (o_req_stall),
        .i_req         (i_req),
        .o_resp_valid  (o_resp_valid),
        .i_resp_stall  (i_resp_stall),
        .o_resp        (o_resp),
        .o_mem_wr_en   (mem_wr_en),
        .o_mem_wr_addr (mem_wr_addr),
        .o_mem_wr_data (mem_wr_data),
        .o_mem_rd_en   (mem_rd_en),
        .o_mem_rd_addr (mem_rd_addr),
        .i_mem_rd_data (mem_rd_data)
    );

    // Entry memory
    psq_ram #(
        .WIDTH (DATA_WIDTH),
        .DEPTH (DEPTH)
    ) u_entries (
        .i_clk     (i_clk),
        .i_wr_en   (mem_wr_en),
        .i_wr_addr (mem_wr_addr),
        .i_wr_data (mem_wr_data),
        .i_rd_en   (mem_rd_en),
        .i_rd_addr (mem_rd_addr),
        .o_rd_data (mem_rd_data)
    );

endmodule

@@ hw/rtl/psq_checker.sv @@
// ----------------------------------------------------------------------------
// psq_checker
// Port-level checks of the positional sequence store, bound to the top level.
// ----------------------------------------------------------------------------
`include "positional_sequence_store_assert.svh"

module psq_checker
    import psq_pkg::*;
#(
    parameter int DEPTH = PSQ_DEPTH
) (
    input logic  i_clk,
    input logic  i_rst_n,
    input logic  i_req_valid,
    input logic  o_req_stall,
    input t_req  i_req,
    input logic  o_resp_valid,
    input logic  i_resp_stall,
    input t_resp o_resp
);

    localparam logic [4:0] FULL_CNT = 5'(DEPTH);

    // Hold a stalled request
    `PSQ_ASSERT_NEXT(a_req_hold, i_req_valid && o_req_stall, i_req_valid && $stable(i_req))

    // Hold a stalled response
    `PSQ_ASSERT_NEXT(a_resp_hold, o_resp_valid && i_resp_stall, o_resp_valid && $stable(o_resp))

    // Stall the next request after one is taken
    `PSQ_ASSERT_NEXT(a_busy_after_accept, i_req_valid && !o_req_stall, o_req_stall)

    // A new response only appears while a request is being worked
    `PSQ_ASSERT_SAME(a_resp_from_busy, $rose(o_resp_valid), $past(o_req_stall))

    // Report full only at full count
    `PSQ_ASSERT_SAME(a_full_count, o_resp_valid && (o_resp.status == ST_FULL),
                     o_resp.count == FULL_CNT)

endmodule

bind positional_sequence_store psq_checker #(
    .DEPTH (DEPTH)
) u_psq_checker (
    .i_clk        (i_clk),
    .i_rst_n      (i_rst_n),
    .i_req_valid  (i_req_valid),
    .o_req_stall  (o_req_stall),
    .i_req        (i_req),
    .o_resp_valid (o_resp_valid),
    .i_resp_stall (i_resp_stall),
    .o_resp       (o_resp)
);
